[rtl/cloud_sky_pixel_classifier_unit_defines.svh]
// assertion macros shared by the sky / cloud / ground classifier rtl
// no dependencies; included by the modules that carry assertions
`ifndef CLOUD_SKY_PIXEL_CLASSIFIER_UNIT_DEFINES_SVH
`define CLOUD_SKY_PIXEL_CLASSIFIER_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define CSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// condition must hold in the cycle after the trigger
`define CSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// condition must never be seen
`define CSP_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

[rtl/csp_pkg.sv]
// shared types, codes and constants of the sky / cloud / ground classifier
// no dependencies; imported by every module of the block
`default_nettype none

package csp_pkg;

   // register widths
   localparam int THRESHOLD_W = 11;
   localparam int HORIZON_W   = 13;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   // result field widths
   localparam int CLASS_W     = 2;
   localparam int ROW_FIELD_W = 12;
   localparam int COL_FIELD_W = 10;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HORIZON   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT    = 2'd3;

   // register reset values
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 11'd490;
   localparam logic [HORIZON_W-1:0]   HORIZON_RESET   = 13'd280;
   localparam logic [WIDTH_W-1:0]     WIDTH_RESET     = 11'd640;
   localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET    = 13'd480;

   // request opcodes
   localparam logic OPC_PIXEL = 1'b0;
   localparam logic OPC_FLUSH = 1'b1;

   // pixel classes
   localparam logic [CLASS_W-1:0] CLASS_SKY      = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_INTERIOR = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_GROUND   = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_BOUNDARY = 2'd3;

   // line store banks, one per row modulo three
   localparam int BANK_COUNT = 3;
   localparam int BANK_W     = 2;

   // entries of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       opcode;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } csp_req_type;

   typedef struct packed {
      logic [CLASS_W-1:0]     pixel_class;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] column;
      logic                   last_of_frame;
   } csp_rsp_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic                   emit;
      logic                   last;
      logic                   wr_en;
      logic                   wr_data;
      logic [BANK_W-1:0]      wr_bank;
      logic [BANK_W-1:0]      rd_bank;
      logic                   ground;
      logic                   center_ok;
      logic                   has_up;
      logic                   has_down;
      logic                   has_left;
      logic                   has_right;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] column;
   } csp_work_type;

   function automatic logic [BANK_W-1:0] bank_next(input logic [BANK_W-1:0] bank);
      logic [BANK_W-1:0] result;
      if (bank == BANK_W'(BANK_COUNT - 1)) begin
         result = '0;
      end else begin
         result = bank + 1'b1;
      end
      return result;
   endfunction

   function automatic logic [BANK_W-1:0] bank_prev(input logic [BANK_W-1:0] bank);
      logic [BANK_W-1:0] result;
      if (bank == '0) begin
         result = BANK_W'(BANK_COUNT - 1);
      end else begin
         result = bank - 1'b1;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/csp_front.sv]
// front end: configuration registers, raster position tracking, cloud test
// depends on csp_pkg; feeds work items into csp_queue
`default_nettype none

module csp_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [csp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [csp_pkg::CSR_DATA_W-1:0]       csr_data,
   input  wire logic                                 req_valid,
   input  wire csp_pkg::csp_req_type                 req_payload,
   input  wire logic                                 queue_full,
   output logic                                      req_stall,
   output logic                                      push,
   output csp_pkg::csp_work_type                     push_work,
   output logic [$clog2(MAX_WIDTH)-1:0]              push_wr_col,
   output logic [$clog2(MAX_WIDTH)-1:0]              push_rd_col
);
   import csp_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
   localparam int CW    = ((COL_W > WIDTH_W) ? COL_W : WIDTH_W) + 1;
   localparam int RW    = ((ROW_W > HEIGHT_W) ? ROW_W : HEIGHT_W) + 1;

   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [HORIZON_W-1:0]   horizon_ff;
   logic [WIDTH_W-1:0]     frame_width_ff;
   logic [HEIGHT_W-1:0]    frame_height_ff;

   logic [ROW_W-1:0]  in_row_ff,   in_row_in;
   logic [COL_W-1:0]  in_col_ff,   in_col_in;
   logic [BANK_W-1:0] in_bank_ff,  in_bank_in;
   logic [ROW_W-1:0]  out_row_ff,  out_row_in;
   logic [COL_W-1:0]  out_col_ff,  out_col_in;
   logic [BANK_W-1:0] out_bank_ff, out_bank_in;

   logic          accept;
   logic [CW-1:0] fw_x, eff_w, in_col_x, out_col_x;
   logic [RW-1:0] fh_x, eff_h, in_row_x, out_row_x, horizon_x;
   logic          emit, last, in_in_frame;
   logic [7:0]    max_c, min_c;
   logic [18:0]   spread, scaled;
   logic          cloud;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= THRESHOLD_RESET;
         horizon_ff      <= HORIZON_RESET;
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_THRESHOLD: threshold_ff    <= csr_data[THRESHOLD_W-1:0];
            CSR_HORIZON:   horizon_ff      <= csr_data[HORIZON_W-1:0];
            CSR_WIDTH:     frame_width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_HEIGHT:    frame_height_ff <= csr_data[HEIGHT_W-1:0];
         endcase
      end
   end

   // saturation test on the incoming pixel
   always_comb begin
      max_c = req_payload.red;
      min_c = req_payload.red;
      if (req_payload.green > max_c) max_c = req_payload.green;
      if (req_payload.blue > max_c) max_c = req_payload.blue;
      if (req_payload.green < min_c) min_c = req_payload.green;
      if (req_payload.blue < min_c) min_c = req_payload.blue;
      spread = 19'({max_c - min_c, 10'b0});
      scaled = 19'(threshold_ff) * 19'(max_c);
      cloud  = spread < scaled;
   end

   always_comb begin
      fw_x = CW'(frame_width_ff);
      if (fw_x == '0) begin
         eff_w = CW'(1);
      end else if (fw_x > CW'(MAX_WIDTH)) begin
         eff_w = CW'(MAX_WIDTH);
      end else begin
         eff_w = fw_x;
      end
      fh_x = RW'(frame_height_ff);
      if (fh_x == '0) begin
         eff_h = RW'(1);
      end else if (fh_x > RW'(MAX_HEIGHT)) begin
         eff_h = RW'(MAX_HEIGHT);
      end else begin
         eff_h = fh_x;
      end
   end

   always_comb begin
      in_col_x  = CW'(in_col_ff);
      in_row_x  = RW'(in_row_ff);
      out_col_x = CW'(out_col_ff);
      out_row_x = RW'(out_row_ff);
      horizon_x = RW'(horizon_ff);

      // output runs width+1 positions behind the input
      emit = (in_row_x >= RW'(2)) || ((in_row_x == RW'(1)) && (in_col_x != '0))
          || (in_col_x >= eff_w + CW'(1));
      last = emit && (out_row_x + RW'(1) >= eff_h) && (out_col_x + CW'(1) >= eff_w);
      in_in_frame = (in_row_x < eff_h) && (in_col_x < eff_w);

      push_work.emit      = emit;
      push_work.last      = last;
      push_work.wr_en     = in_in_frame && !last;
      push_work.wr_data   = (req_payload.opcode == OPC_PIXEL) && (in_row_x < horizon_x) && cloud;
      push_work.wr_bank   = in_bank_ff;
      push_work.rd_bank   = out_bank_ff;
      push_work.ground    = out_row_x >= horizon_x;
      push_work.center_ok = (out_row_x < eff_h) && (out_col_x < eff_w);
      push_work.has_up    = out_row_x != '0;
      push_work.has_down  = out_row_x + RW'(1) < eff_h;
      push_work.has_left  = out_col_x != '0;
      push_work.has_right = out_col_x + CW'(1) < eff_w;
      push_work.row       = ROW_FIELD_W'(out_row_ff);
      push_work.column    = COL_FIELD_W'(out_col_ff);
      push_wr_col         = in_col_ff;
      push_rd_col         = out_col_ff;

      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_bank_in  = in_bank_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_bank_in = out_bank_ff;

      if (accept) begin
         if (emit) begin
            if (last) begin
               out_row_in  = '0;
               out_col_in  = '0;
               out_bank_in = '0;
            end else if (out_col_x + CW'(1) >= eff_w) begin
               out_col_in = '0;
               if (out_row_ff < ROW_W'(MAX_HEIGHT + 2)) begin
                  out_row_in  = out_row_ff + 1'b1;
                  out_bank_in = bank_next(out_bank_ff);
               end
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
         if (last) begin
            in_row_in  = '0;
            in_col_in  = '0;
            in_bank_in = '0;
         end else if (in_col_x + CW'(1) >= eff_w) begin
            in_col_in = '0;
            if (in_row_ff < ROW_W'(MAX_HEIGHT + 2)) begin
               in_row_in  = in_row_ff + 1'b1;
               in_bank_in = bank_next(in_bank_ff);
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_bank_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_bank_ff <= '0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_bank_ff  <= in_bank_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_bank_ff <= out_bank_in;
      end
   end

endmodule

`default_nettype wire

[rtl/csp_queue.sv]
// short first-in first-out queue that decouples the front from the back
// depends on csp_pkg for its depth
`default_nettype none

`include "cloud_sky_pixel_classifier_unit_defines.svh"

module csp_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output logic [DATA_W-1:0]      pop_data
);
   import csp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   assign full      = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CSP_ASSERT_NEVER(a_queue_no_overflow, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH))
   `CSP_ASSERT_SAME(a_queue_pop_nonempty, clock, reset, pop, count_ff != '0)
   `CSP_ASSERT_NEXT(a_queue_fill_step, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

[rtl/csp_back.sv]
// back end: cloud line stores, four-neighbour boundary test, result register
// depends on csp_pkg; takes work items from csp_queue
`default_nettype none

`include "cloud_sky_pixel_classifier_unit_defines.svh"

module csp_back #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          work_valid,
   input  wire csp_pkg::csp_work_type         work,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
   output logic                               pop,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output csp_pkg::csp_rsp_type               rsp_payload
);
   import csp_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // three copies of the row-banked cloud flags give five reads per cycle
   logic line_a_mem [0:BANK_COUNT-1][0:MAX_WIDTH-1];
   logic line_b_mem [0:BANK_COUNT-1][0:MAX_WIDTH-1];
   logic line_c_mem [0:BANK_COUNT-1][0:MAX_WIDTH-1];

   logic [COL_W-1:0] col_left, col_right;

   logic         stage_valid_ff, stage_valid_in;
   csp_work_type stage_work_ff;
   logic         up_ff, down_ff, left_ff, right_ff, center_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   csp_rsp_type  rsp_payload_ff;

   logic         out_ready, stage_adv, stage_take, stage_emit;
   logic         edge_found;
   logic [CLASS_W-1:0] pixel_class;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign stage_emit = stage_valid_ff && stage_work_ff.emit;
   assign stage_adv  = stage_valid_ff && (!stage_work_ff.emit || out_ready);
   assign stage_take = !stage_valid_ff || stage_adv;
   assign pop        = work_valid && stage_take;

   // neighbour columns, held in range when masked off
   assign col_left  = (rd_col == '0) ? '0 : rd_col - 1'b1;
   assign col_right = (rd_col == COL_W'(MAX_WIDTH - 1)) ? '0 : rd_col + 1'b1;

   always_ff @(posedge clock) begin
      if (pop && work.wr_en) begin
         line_a_mem[work.wr_bank][wr_col] <= work.wr_data;
      end
      if (pop) begin
         left_ff  <= line_a_mem[work.rd_bank][col_left];
         right_ff <= line_a_mem[work.rd_bank][col_right];
      end
   end

   always_ff @(posedge clock) begin
      if (pop && work.wr_en) begin
         line_b_mem[work.wr_bank][wr_col] <= work.wr_data;
      end
      if (pop) begin
         center_ff <= line_b_mem[work.rd_bank][rd_col];
         up_ff     <= line_b_mem[bank_prev(work.rd_bank)][rd_col];
      end
   end

   always_ff @(posedge clock) begin
      if (pop && work.wr_en) begin
         line_c_mem[work.wr_bank][wr_col] <= work.wr_data;
      end
      if (pop) begin
         down_ff <= line_c_mem[bank_next(work.rd_bank)][rd_col];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         stage_work_ff <= work;
      end
   end

   always_comb begin
      edge_found = (stage_work_ff.has_up && !up_ff)
                || (stage_work_ff.has_down && !down_ff)
                || (stage_work_ff.has_left && !left_ff)
                || (stage_work_ff.has_right && !right_ff);
      priority if (stage_work_ff.ground) begin
         pixel_class = CLASS_GROUND;
      end else if (!(stage_work_ff.center_ok && center_ff)) begin
         pixel_class = CLASS_SKY;
      end else if (edge_found) begin
         pixel_class = CLASS_BOUNDARY;
      end else begin
         pixel_class = CLASS_INTERIOR;
      end
   end

   always_comb begin
      if (pop) begin
         stage_valid_in = 1'b1;
      end else if (stage_adv) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
      rsp_valid_in = out_ready ? stage_emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_emit && out_ready) begin
         rsp_payload_ff.pixel_class   <= pixel_class;
         rsp_payload_ff.row           <= stage_work_ff.row;
         rsp_payload_ff.column        <= stage_work_ff.column;
         rsp_payload_ff.last_of_frame <= stage_work_ff.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a classified pixel blocked at the output stays in the stage
   `CSP_ASSERT_NEXT(a_back_stage_holds, clock, reset, stage_emit && !out_ready, stage_emit)

endmodule

`default_nettype wire

[rtl/cloud_sky_pixel_classifier_unit.sv]
// sky / cloud / ground pixel classifier: front, queue and back; needs csp_pkg
// throughput one request per cycle unless the queue is full, set by the front's
// raster position update; a result goes through the queue, stage and result
// registers; it is for the pixel accepted frame width plus one requests earlier
// synchronous reset restores registers, positions, queue and output stage;
// the cloud line stores are not cleared and need no clearing pass
`default_nettype none

module cloud_sky_pixel_classifier_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [csp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [csp_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire csp_pkg::csp_req_type            req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output csp_pkg::csp_rsp_type                 rsp_payload
);
   import csp_pkg::*;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int QDATA_W = $bits(csp_work_type) + 2 * COL_W;

   logic               queue_full, push, pop, pop_valid;
   csp_work_type       push_work, pop_work;
   logic [COL_W-1:0]   push_wr_col, push_rd_col, pop_wr_col, pop_rd_col;
   logic [QDATA_W-1:0] push_data, pop_data;

   assign push_data = {push_work, push_wr_col, push_rd_col};
   assign {pop_work, pop_wr_col, pop_rd_col} = pop_data;

   csp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_payload  (req_payload),
      .queue_full   (queue_full),
      .req_stall    (req_stall),
      .push         (push),
      .push_work    (push_work),
      .push_wr_col  (push_wr_col),
      .push_rd_col  (push_rd_col)
   );

   csp_queue #(
      .DATA_W (QDATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   csp_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .work_valid  (pop_valid),
      .work        (pop_work),
      .wr_col      (pop_wr_col),
      .rd_col      (pop_rd_col),
      .pop         (pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
